// File: design/wprw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wprw_pkg
// Shared types, codes and sizes for the writer-preferring readers-writer
// lock manager.
// ----------------------------------------------------------------------------
package wprw_pkg;

  // Sizes
  localparam int QUEUE_DEPTH  = 16;
  localparam int TASK_ID_BITS = 8;
  localparam int TID_W        = TASK_ID_BITS;
  localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int RC_W         = 9;
  localparam logic [RC_W-1:0] READER_MAX = {RC_W{1'b1}};

  // Request codes
  localparam logic [2:0] OP_RD_WAIT = 3'd0;
  localparam logic [2:0] OP_RD_TRY  = 3'd1;
  localparam logic [2:0] OP_RD_REL  = 3'd2;
  localparam logic [2:0] OP_WR_WAIT = 3'd3;
  localparam logic [2:0] OP_WR_TRY  = 3'd4;
  localparam logic [2:0] OP_WR_REL  = 3'd5;

  // Result status codes
  localparam logic [2:0] STAT_GRANTED  = 3'd0;
  localparam logic [2:0] STAT_QUEUED   = 3'd1;
  localparam logic [2:0] STAT_REFUSED  = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_WOKE_R   = 3'd4;
  localparam logic [2:0] STAT_WOKE_W   = 3'd5;
  localparam logic [2:0] STAT_RELEASED = 3'd6;
  localparam logic [2:0] STAT_REL_ERR  = 3'd7;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAKE_R,
    S_WAKE_W
  } state_t;

  // Queue control and status
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Advance a ring pointer with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/writer_priority_rw_lock_manager_core.sv
`default_nettype none
// Sequencing: a request is taken in S_IDLE and decided in S_EXEC once the
//   output is free, which registers its first result word; a release that
//   wakes a task pops a queue instead, and the word goes out in a wake state.
// Throughput: in_stall holds off new requests until the last one is done;
//   woken readers leave at one wake per cycle while the output is not stalled.
// Reset: synchronous rst clears counts, owner, queue pointers and sequencer;
//   queue memories are not cleared.
// ----------------------------------------------------------------------------
// writer_priority_rw_lock_manager_core
// Readers-writer lock with FIFO queues of waiting readers and writers;
// writers take priority over new readers.
// ----------------------------------------------------------------------------
module writer_priority_rw_lock_manager_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  operation,
  input  wire logic [wprw_pkg::TID_W-1:0]  task_id,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [2:0]                  status,
  output logic      [wprw_pkg::TID_W-1:0]  task_id_out,
  output logic                             last
);

  wprw_pkg::state_t           state;
  wprw_pkg::state_t           state_next;
  logic [2:0]                 op;
  logic [wprw_pkg::TID_W-1:0] tid;
  logic [wprw_pkg::RC_W-1:0]  reader_count;
  logic [wprw_pkg::RC_W-1:0]  reader_count_next;
  logic                       writer_held;
  logic                       writer_held_next;
  logic [wprw_pkg::TID_W-1:0] writer_owner;
  logic [wprw_pkg::TID_W-1:0] writer_owner_next;

  wprw_pkg::q_ctrl_t          rq_ctrl;
  wprw_pkg::q_ctrl_t          wq_ctrl;
  wprw_pkg::q_stat_t          rq_stat;
  wprw_pkg::q_stat_t          wq_stat;
  logic [wprw_pkg::TID_W-1:0] rq_rdata;
  logic [wprw_pkg::TID_W-1:0] wq_rdata;

  logic                       ofree;
  logic                       emit;
  logic [2:0]                 emit_status;
  logic [wprw_pkg::TID_W-1:0] emit_tid;
  logic                       emit_last;
  logic                       to_wake_r;
  logic                       to_wake_w;
  logic                       done;

  // Waiting queues
  wprw_queue u_rq (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (rq_ctrl),
    .wdata (tid),
    .stat  (rq_stat),
    .rdata (rq_rdata)
  );

  wprw_queue u_wq (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (wq_ctrl),
    .wdata (tid),
    .stat  (wq_stat),
    .rdata (wq_rdata)
  );

  assign in_stall = (state != wprw_pkg::S_IDLE);
  assign ofree    = !out_valid || !out_stall;

  // Latch the request word
  always_ff @(posedge clk) begin
    if (state == wprw_pkg::S_IDLE && in_valid) begin
      op  <= operation;
      tid <= task_id;
    end
  end

  // Decide the request and drive lock updates and result words
  always_comb begin
    emit              = 1'b0;
    emit_status       = wprw_pkg::STAT_RELEASED;
    emit_tid          = '0;
    emit_last         = 1'b1;
    reader_count_next = reader_count;
    writer_held_next  = writer_held;
    writer_owner_next = writer_owner;
    rq_ctrl           = '0;
    wq_ctrl           = '0;
    to_wake_r         = 1'b0;
    to_wake_w         = 1'b0;
    done              = 1'b0;
    unique case (state)
      wprw_pkg::S_IDLE: begin
      end
      wprw_pkg::S_EXEC: begin
        if (ofree) begin
          unique case (op) inside
            wprw_pkg::OP_RD_WAIT, wprw_pkg::OP_RD_TRY: begin
              emit     = 1'b1;
              emit_tid = tid;
              done     = 1'b1;
              if (!writer_held && wq_stat.empty) begin
                if (reader_count == wprw_pkg::READER_MAX) begin
                  emit_status = wprw_pkg::STAT_REFUSED;
                end else begin
                  reader_count_next = reader_count + 1'b1;
                  emit_status       = wprw_pkg::STAT_GRANTED;
                end
              end else if (op == wprw_pkg::OP_RD_TRY) begin
                emit_status = wprw_pkg::STAT_REFUSED;
              end else if (rq_stat.full) begin
                emit_status = wprw_pkg::STAT_FULL;
              end else begin
                rq_ctrl.push = 1'b1;
                emit_status  = wprw_pkg::STAT_QUEUED;
              end
            end
            wprw_pkg::OP_RD_REL: begin
              if (reader_count == '0) begin
                emit        = 1'b1;
                emit_status = wprw_pkg::STAT_REL_ERR;
                done        = 1'b1;
              end else begin
                reader_count_next = reader_count - 1'b1;
                // Last reader out hands the lock to the oldest writer
                if (reader_count == wprw_pkg::RC_W'(1) && !wq_stat.empty) begin
                  wq_ctrl.pop = 1'b1;
                  to_wake_w   = 1'b1;
                end else begin
                  emit        = 1'b1;
                  emit_status = wprw_pkg::STAT_RELEASED;
                  done        = 1'b1;
                end
              end
            end
            wprw_pkg::OP_WR_WAIT, wprw_pkg::OP_WR_TRY: begin
              emit     = 1'b1;
              emit_tid = tid;
              done     = 1'b1;
              if (!writer_held && reader_count == '0) begin
                writer_held_next  = 1'b1;
                writer_owner_next = tid;
                emit_status       = wprw_pkg::STAT_GRANTED;
              end else if (op == wprw_pkg::OP_WR_TRY) begin
                emit_status = wprw_pkg::STAT_REFUSED;
              end else if (wq_stat.full) begin
                emit_status = wprw_pkg::STAT_FULL;
              end else begin
                wq_ctrl.push = 1'b1;
                emit_status  = wprw_pkg::STAT_QUEUED;
              end
            end
            wprw_pkg::OP_WR_REL: begin
              if (!writer_held) begin
                emit        = 1'b1;
                emit_status = wprw_pkg::STAT_REL_ERR;
                done        = 1'b1;
              end else begin
                writer_held_next  = 1'b0;
                writer_owner_next = '0;
                // Waiting readers go first, else the oldest writer
                if (!rq_stat.empty) begin
                  rq_ctrl.pop = 1'b1;
                  to_wake_r   = 1'b1;
                end else if (reader_count == '0 && !wq_stat.empty) begin
                  wq_ctrl.pop = 1'b1;
                  to_wake_w   = 1'b1;
                end else begin
                  emit        = 1'b1;
                  emit_status = wprw_pkg::STAT_RELEASED;
                  done        = 1'b1;
                end
              end
            end
            default: begin
              emit        = 1'b1;
              emit_status = wprw_pkg::STAT_REFUSED;
              emit_tid    = tid;
              done        = 1'b1;
            end
          endcase
        end
      end
      wprw_pkg::S_WAKE_R: begin
        // One woken reader per cycle unless stalled; fetch the next as it leaves
        if (ofree) begin
          emit        = 1'b1;
          emit_status = wprw_pkg::STAT_WOKE_R;
          emit_tid    = rq_rdata;
          if (reader_count != wprw_pkg::READER_MAX) begin
            reader_count_next = reader_count + 1'b1;
          end
          if (!rq_stat.empty) begin
            rq_ctrl.pop = 1'b1;
            emit_last   = 1'b0;
          end else begin
            done = 1'b1;
          end
        end
      end
      wprw_pkg::S_WAKE_W: begin
        if (ofree) begin
          emit              = 1'b1;
          emit_status       = wprw_pkg::STAT_WOKE_W;
          emit_tid          = wq_rdata;
          writer_held_next  = 1'b1;
          writer_owner_next = wq_rdata;
          done              = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      wprw_pkg::S_IDLE: begin
        if (in_valid) state_next = wprw_pkg::S_EXEC;
      end
      wprw_pkg::S_EXEC: begin
        if (to_wake_r) state_next = wprw_pkg::S_WAKE_R;
        else if (to_wake_w) state_next = wprw_pkg::S_WAKE_W;
        else if (done) state_next = wprw_pkg::S_IDLE;
      end
      wprw_pkg::S_WAKE_R: begin
        if (done) state_next = wprw_pkg::S_IDLE;
      end
      wprw_pkg::S_WAKE_W: begin
        if (done) state_next = wprw_pkg::S_IDLE;
      end
      default: state_next = wprw_pkg::S_IDLE;
    endcase
  end

  // Hold sequencer and lock state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wprw_pkg::S_IDLE;
      reader_count <= '0;
      writer_held  <= 1'b0;
      writer_owner <= '0;
    end else begin
      state        <= state_next;
      reader_count <= reader_count_next;
      writer_held  <= writer_held_next;
      writer_owner <= writer_owner_next;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= emit_status;
      task_id_out <= emit_tid;
      last        <= emit_last;
    end
  end

  // Lock invariants
  a_owner_clear: assert property (@(posedge clk) disable iff (rst)
    !writer_held |-> writer_owner == '0)
    else $error("writer owner set while no writer holds the lock");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    writer_held |-> reader_count == '0)
    else $error("writer holds the lock while readers are counted");

  a_drain_no_writer: assert property (@(posedge clk) disable iff (rst)
    state == wprw_pkg::S_WAKE_R |-> !writer_held)
    else $error("writer held during reader wake-up");

  a_wake_w_free: assert property (@(posedge clk) disable iff (rst)
    state == wprw_pkg::S_WAKE_W |-> (reader_count == '0 && !writer_held))
    else $error("writer wake-up while lock is taken");

endmodule
`default_nettype wire

// File: design/wprw_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wprw_queue
// FIFO of waiting task ids in a synchronous memory; a pop registers the head
// entry onto rdata, valid in the cycle after the pop and held until the next pop.
// ----------------------------------------------------------------------------
module wprw_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire wprw_pkg::q_ctrl_t           ctrl,
  input  wire logic [wprw_pkg::TID_W-1:0]  wdata,
  output wprw_pkg::q_stat_t                stat,
  output logic      [wprw_pkg::TID_W-1:0]  rdata
);

  logic [wprw_pkg::TID_W-1:0] mem [wprw_pkg::QUEUE_DEPTH];
  logic [wprw_pkg::PTR_W-1:0] head;
  logic [wprw_pkg::PTR_W-1:0] tail;
  logic [wprw_pkg::CNT_W-1:0] count;
  logic [wprw_pkg::CNT_W-1:0] count_next;

  // Write at tail, read at head
  always_ff @(posedge clk) begin
    if (ctrl.push) mem[tail] <= wdata;
    if (ctrl.pop) rdata <= mem[head];
  end

  // Track occupancy
  always_comb begin
    case ({ctrl.push, ctrl.pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.push) tail <= wprw_pkg::ptr_inc(tail);
      if (ctrl.pop) head <= wprw_pkg::ptr_inc(head);
      count <= count_next;
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == wprw_pkg::CNT_W'(wprw_pkg::QUEUE_DEPTH));

endmodule
`default_nettype wire
